### src/dual_quadrature_step_counter_assert.svh
// Assertion macros shared by the checker of the dual quadrature step counter.
`ifndef DUAL_QUADRATURE_STEP_COUNTER_ASSERT_SVH
`define DUAL_QUADRATURE_STEP_COUNTER_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define DQSC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dqsc assertion failed");

// Checks that cons holds in the cycle after ante.
`define DQSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dqsc assertion failed");

`endif

### src/dqsc_pkg.sv
// Types, constants and the Gray sequence function of the dual quadrature step counter.
`default_nettype none

package dqsc_pkg;

    localparam int COUNT_W = 10;
    localparam int STEP_W  = 3;
    localparam int PINS_W  = 4;

    typedef logic [1:0]         phase_t;
    typedef logic [1:0]         steps_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [STEP_W-1:0]  step_t;
    typedef logic [PINS_W-1:0]  pins_t;

    // Detents that one encoder produces for one sample.
    typedef struct packed {
        logic up;
        logic down;
    } detent_t;

    // Clockwise successor of a phase state in the Gray sequence 0, 1, 3, 2.
    function automatic phase_t cw_next(input phase_t p);
        phase_t r;
        case (p)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd3;
            2'd3:    r = 2'd2;
            2'd2:    r = 2'd0;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### src/dqsc_track.sv
// One encoder's phase history and its two transition counters.
`default_nettype none

module dqsc_track
    import dqsc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    advance,
    input  wire phase_t  phase,
    output detent_t      detent
);

    phase_t prev_reg;
    steps_t cw_reg;
    steps_t ccw_reg;
    steps_t cw_next_val;
    steps_t ccw_next_val;
    logic   move_cw;
    logic   move_ccw;

    always_comb
    begin
        move_cw  = (cw_next(prev_reg) == phase);
        move_ccw = !move_cw && (cw_next(phase) == prev_reg);
        // A counter at three that takes one more move completes a detent and
        // rolls over to zero by itself.
        cw_next_val  = move_cw  ? cw_reg + 2'd1  : cw_reg;
        ccw_next_val = move_ccw ? ccw_reg + 2'd1 : ccw_reg;
        detent.up    = move_cw  && (cw_reg == 2'd3);
        detent.down  = move_ccw && (ccw_reg == 2'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            cw_reg   <= '0;
            ccw_reg  <= '0;
        end
        else if (advance)
        begin
            prev_reg <= phase;
            cw_reg   <= cw_next_val;
            ccw_reg  <= ccw_next_val;
        end
    end

endmodule

`default_nettype wire

### src/dual_quadrature_step_counter.sv
// Top level of the dual quadrature step counter.
`default_nettype none

// Dual quadrature step counter. Each input word carries one sample of two
// quadrature encoders (enc_pins bits 1:0 for encoder A, bits 3:2 for encoder B)
// and a step size. Valid Gray-code moves advance per-encoder clockwise and
// counter-clockwise transition counters; every fourth move in one direction is
// a detent that moves the shared 10-bit position up (clockwise) or down
// (counter-clockwise) by step_size, modulo 1024. Double-bit jumps are ignored
// apart from updating the stored phase. Every input word yields exactly one
// output word carrying the position after that sample. The block accepts one
// word per cycle while in_stall is low. A word is held in the input register,
// and its result is loaded into the output register once that register is
// free; the position is presented from there. The phase compare and the
// four-term position add sit between the two registers. in_stall rises only
// when both registers are full and the output side is stalling.
module dual_quadrature_step_counter
    import dqsc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_stall,
    input  wire pins_t  enc_pins,
    input  wire step_t  step_size,
    output logic        out_valid,
    input  wire logic   out_stall,
    output count_t      position
);

    // Input register.
    logic    s1_valid_reg;
    pins_t   s1_pins_reg;
    step_t   s1_step_reg;

    // Output register; it also holds the running count.
    logic    out_valid_reg;
    count_t  count_reg;
    count_t  count_next;

    logic    out_free;
    logic    s1_move;
    logic    in_take;
    count_t  step_ext;
    detent_t detent_a;
    detent_t detent_b;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign position  = count_reg;

    dqsc_track u_track_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_move),
        .phase   (s1_pins_reg[1:0]),
        .detent  (detent_a)
    );

    dqsc_track u_track_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_move),
        .phase   (s1_pins_reg[3:2]),
        .detent  (detent_b)
    );

    // The order of the detents does not matter for a sum modulo 1024, so the
    // four contributions are folded in one expression.
    always_comb
    begin
        step_ext   = {{(COUNT_W-STEP_W){1'b0}}, s1_step_reg};
        count_next = count_reg
                   + (detent_a.up   ? step_ext : '0)
                   - (detent_a.down ? step_ext : '0)
                   + (detent_b.up   ? step_ext : '0)
                   - (detent_b.down ? step_ext : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pins_reg <= enc_pins;
            s1_step_reg <= step_size;
        end
    end

endmodule

`default_nettype wire

### src/dqsc_checker.sv
// Port-level checker of the dual quadrature step counter and its bind.
`default_nettype none

`include "dual_quadrature_step_counter_assert.svh"

module dqsc_checker
    import dqsc_pkg::*;
(
    input wire logic   clk,
    input wire logic   rst_n,
    input wire logic   in_valid,
    input wire logic   in_stall,
    input wire pins_t  enc_pins,
    input wire step_t  step_size,
    input wire logic   out_valid,
    input wire logic   out_stall,
    input wire count_t position
);

    // A stalled output word stays.
    `DQSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(position))
    // The input only waits when the output side is full and stalling.
    `DQSC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
    // The position only moves when a new word is presented.
    `DQSC_ASSERT_NOW(a_pos_change, !$stable(position), out_valid)
    // A word taken while the output is empty is presented after passing the input and output registers.
    `DQSC_ASSERT_NEXT(a_latency, in_valid && !in_stall && !out_valid, ##1 out_valid)

endmodule

bind dual_quadrature_step_counter dqsc_checker u_dqsc_checker (.*);

`default_nettype wire

### verif/position_checker.sv
// Checker that predicts and compares the position words of the dual quadrature step counter.
module position_checker
    import dqsc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    input  wire logic   in_stall,
    input  wire pins_t  enc_pins,
    input  wire step_t  step_size,
    input  wire logic   out_valid,
    input  wire logic   out_stall,
    input  wire count_t position,
    output int unsigned fail_count,
    output int unsigned pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // Clockwise successor of each phase state in the Gray order 0, 1, 3, 2.
    localparam phase_t CW_SUCCESSOR [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
    localparam logic [2:0] MOVES_PER_DETENT = 3'd4;

    phase_t      last_phase [2];
    logic [2:0]  cw_moves [2];
    logic [2:0]  ccw_moves [2];
    count_t      tracked_position;
    count_t      expected_positions [$];
    int unsigned mismatches;

    // Advances the tracked encoder state by one sample and queues the position it yields.
    // Detents are applied as A clockwise, A counter-clockwise, B clockwise, B counter-clockwise.
    task automatic predict_position(input pins_t pins, input step_t step);
        phase_t now;
        for (int e = 0; e < 2; e++)
        begin
            now = pins[2*e +: 2];
            if (CW_SUCCESSOR[last_phase[e]] == now)
            begin
                cw_moves[e] = cw_moves[e] + 3'd1;
            end
            else if (CW_SUCCESSOR[now] == last_phase[e])
            begin
                ccw_moves[e] = ccw_moves[e] + 3'd1;
            end
            last_phase[e] = now;
        end
        for (int e = 0; e < 2; e++)
        begin
            if (cw_moves[e] >= MOVES_PER_DETENT)
            begin
                tracked_position = tracked_position + count_t'(step);
                cw_moves[e] = 3'd0;
            end
            if (ccw_moves[e] >= MOVES_PER_DETENT)
            begin
                tracked_position = tracked_position - count_t'(step);
                ccw_moves[e] = 3'd0;
            end
        end
        expected_positions.push_back(tracked_position);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        count_t wanted;
        if (!rst_n)
        begin
            for (int e = 0; e < 2; e++)
            begin
                last_phase[e] = 2'd0;
                cw_moves[e]   = 3'd0;
                ccw_moves[e]  = 3'd0;
            end
            tracked_position = '0;
            expected_positions.delete();
            mismatches = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_position(enc_pins, step_size);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_positions.size() == 0)
                begin
                    $display("%0t: position word with none expected, expected none, actual %0d",
                             $time, position);
                    mismatches++;
                end
                else
                begin
                    wanted = expected_positions.pop_front();
                    if (position !== wanted)
                    begin
                        $display("%0t: position mismatch, expected %0d, actual %0d",
                                 $time, wanted, position);
                        mismatches++;
                    end
                end
            end
            fail_count    <= mismatches;
            pending_count <= expected_positions.size();
        end
    end

endmodule

### verif/testbench.sv
// Top of the testbench: clock, reset, stimulus, output stalling and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dqsc_pkg::*;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 5;
    localparam int WORDS_PER_PHASE  = 300;
    localparam int LONG_HOLD_CYCLES = 60;
    // Extra cycles allowed after the last position before the verdict.
    localparam int DRAIN_CYCLES     = 8;
    // Bound on the length of the run, far above what a correct run needs.
    localparam int CYCLE_LIMIT      = 200000;

    // Phase states of one encoder in clockwise order; a move is a step along this ring.
    localparam phase_t GRAY_RING [4] = '{2'd0, 2'd1, 2'd3, 2'd2};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    pins_t       enc_pins = '0;
    step_t       step_size = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    count_t      position;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned cycle_count = 0;

    // Percent of cycles in which the sender holds back a word and the receiver stalls.
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    // Set by the stimulus to ask the receiver for one long stall.
    bit          hold_request = 1'b0;

    // Where each encoder currently sits on the Gray ring, and which way it is turning.
    int          ring_index [2] = '{0, 0};
    bit          turning_cw [2] = '{1'b1, 1'b1};

    dual_quadrature_step_counter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .enc_pins  (enc_pins),
        .step_size (step_size),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .position  (position)
    );

    position_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .enc_pins      (enc_pins),
        .step_size     (step_size),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .position      (position),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // A hung handshake must not hang the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver. Each cycle it stalls with the current probability, except when the stimulus
    // asks for a long hold-off; that one is counted here so the sender keeps offering words
    // meanwhile and the block fills up until it stalls its input.
    initial
    begin
        wait (rst_n);
        forever
        begin
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < rx_idle_pct);
                @(posedge clk);
            end
        end
    end

    // Offers one word, after a random number of idle cycles, and returns at the edge that
    // accepts it. The payload is held unchanged while the block stalls it. Valid stays high
    // between back-to-back words.
    task automatic send_word(input pins_t pins, input step_t step);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        enc_pins  <= pins;
        step_size <= step;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Random words that mostly look like real rotation: each encoder keeps turning one way
    // for a while, sometimes steps back, sometimes rests, and now and then jumps anywhere,
    // which also gives double-bit jumps. That keeps the move counters reaching detents.
    task automatic send_random_words(input int count);
        pins_t pins;
        step_t step;
        int    pick;
        for (int n = 0; n < count; n++)
        begin
            for (int e = 0; e < 2; e++)
            begin
                if ($urandom_range(99) < 10)
                begin
                    turning_cw[e] = ~turning_cw[e];
                end
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    ring_index[e] = (ring_index[e] + (turning_cw[e] ? 1 : 3)) % 4;
                end
                else if (pick < 80)
                begin
                    ring_index[e] = (ring_index[e] + (turning_cw[e] ? 3 : 1)) % 4;
                end
                else if (pick >= 90)
                begin
                    ring_index[e] = $urandom_range(3);
                end
                pins[2*e +: 2] = GRAY_RING[ring_index[e]];
            end
            // Mostly the useful step sizes, with the out-of-range ones mixed in.
            if ($urandom_range(99) < 85)
            begin
                step = step_t'($urandom_range(4));
            end
            else
            begin
                step = step_t'($urandom_range(7, 5));
            end
            send_word(pins, step);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 7;
        rx_idle_pct = 65;

        // Directed words, written as {encoder B, encoder A}. First a sample with no change.
        send_word(4'b0000, 3'd2);
        // A full clockwise turn of A with a zero step: a detent that leaves the count alone.
        send_word(4'b0001, 3'd0);
        send_word(4'b0011, 3'd0);
        send_word(4'b0010, 3'd0);
        send_word(4'b0000, 3'd0);
        // A counter-clockwise turn of A with the largest step: the count wraps below zero.
        send_word(4'b0010, 3'd7);
        send_word(4'b0011, 3'd7);
        send_word(4'b0001, 3'd7);
        send_word(4'b0000, 3'd7);
        // A clockwise turn of B with an out-of-range step.
        send_word(4'b0100, 3'd5);
        send_word(4'b1100, 3'd5);
        send_word(4'b1000, 3'd5);
        send_word(4'b0000, 3'd5);
        // Both encoders clockwise together: two detents in the last sample wrap past 1023.
        send_word(4'b0101, 3'd3);
        send_word(4'b1111, 3'd3);
        send_word(4'b1010, 3'd3);
        send_word(4'b0000, 3'd3);
        // A clockwise and B counter-clockwise together: two detents that cancel.
        send_word(4'b1001, 3'd4);
        send_word(4'b1111, 3'd4);
        send_word(4'b0110, 3'd4);
        send_word(4'b0000, 3'd4);
        // Double-bit jumps on both encoders, around a pair of single moves.
        send_word(4'b1111, 3'd1);
        send_word(4'b0000, 3'd1);
        send_word(4'b0110, 3'd1);
        send_word(4'b1001, 3'd1);

        // The random part starts from where the directed words left the encoders:
        // A at phase 1 and B at phase 2.
        ring_index[0] = 1;
        ring_index[1] = 3;
        send_random_words(WORDS_PER_PHASE);

        tx_idle_pct = 65;
        rx_idle_pct = 7;
        send_random_words(WORDS_PER_PHASE);

        // No idling on either side, opened by one long stall of the receiver.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_request = 1'b1;
        send_random_words(WORDS_PER_PHASE);
        in_valid <= 1'b0;

        // Let the checker see the last accepted word, wait for every position, then linger.
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
